>>> design/bls_pkg.sv
// bls_pkg: shared types and constants of the line stepper
// no dependencies; used by bls_stepper and bresenham_line_stepper_top
package bls_pkg;

  // command field of an input word
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_RIGHT  = 3'd2,
    REG_CLIP_BOTTOM = 3'd3,
    REG_PITCH       = 3'd4
  } reg_idx_e;

  // fixed field widths
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 14;
  localparam int ClipLoW  = 11;
  localparam int ClipHiW  = 12;
  localparam int PitchW   = 14;
  localparam int ColorW   = 16;
  localparam int AlphaW   = 6;
  localparam int OffsetW  = 24;

  // register reset values
  localparam logic [ClipLoW-1:0] ClipLeftRst   = 11'd0;
  localparam logic [ClipLoW-1:0] ClipTopRst    = 11'd0;
  localparam logic [ClipHiW-1:0] ClipRightRst  = 12'd2048;
  localparam logic [ClipHiW-1:0] ClipBottomRst = 12'd2048;
  localparam logic [PitchW-1:0]  PitchRst      = 14'd4096;

  // status from the stepper core for the accepted word
  typedef struct packed {
    logic pix_ok;  // step on an active line: a pixel comes out
    logic last;    // current pixel is the line's final one
  } step_stat_t;

endpackage

>>> design/bls_stepper.sv
// bls_stepper: Bresenham line state, start setup and per-pixel stepping
// depends on bls_pkg
module bls_stepper import bls_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic                         cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic        [ColorW-1:0]     color_i,
  input  logic        [AlphaW-1:0]     alpha_i,
  input  logic                         blend_i,
  output step_stat_t                   stat_o,
  output logic signed [COORD_BITS-1:0] cur_x_o,
  output logic signed [COORD_BITS-1:0] cur_y_o,
  output logic        [ColorW-1:0]     color_o,
  output logic        [AlphaW-1:0]     alpha_o,
  output logic                         blend_o
);

  localparam int DW   = COORD_BITS + 1;
  localparam int ErrW = COORD_BITS + 3;

  logic                         active_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, stop_x_q, stop_y_q;
  logic signed [ErrW-1:0]       err_q;
  logic        [DW-1:0]         tdx_q, tdy_q;
  logic                         sxn_q, syn_q, xmaj_q;
  logic        [ColorW-1:0]     color_q;
  logic        [AlphaW-1:0]     alpha_q;
  logic                         blend_q;

  // setup of a new line
  logic signed [DW-1:0]         dx, dy, neg_dx, neg_dy;
  logic        [COORD_BITS-1:0] adx, ady;
  logic        [DW-1:0]         tdx, tdy;
  logic                         xmaj;
  logic signed [ErrW-1:0]       err_init;

  assign dx     = $signed({end_x_i[COORD_BITS-1], end_x_i})
                - $signed({start_x_i[COORD_BITS-1], start_x_i});
  assign dy     = $signed({end_y_i[COORD_BITS-1], end_y_i})
                - $signed({start_y_i[COORD_BITS-1], start_y_i});
  assign neg_dx = -dx;
  assign neg_dy = -dy;
  assign adx    = dx[DW-1] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ady    = dy[DW-1] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign tdx    = {adx, 1'b0};
  assign tdy    = {ady, 1'b0};
  assign xmaj   = tdx > tdy;
  assign err_init = xmaj ? $signed({2'b00, tdy}) - $signed({3'b000, adx})
                         : $signed({2'b00, tdx}) - $signed({3'b000, ady});

  // one step along the line
  logic                         err_ge, done, move_x, move_y;
  logic        [DW-1:0]         tmaj, tmin;
  logic signed [ErrW-1:0]       err_nxt;
  logic        [COORD_BITS-1:0] inc_x, inc_y;

  assign err_ge  = !err_q[ErrW-1];
  assign done    = xmaj_q ? (cur_x_q == stop_x_q) : (cur_y_q == stop_y_q);
  assign tmaj    = xmaj_q ? tdx_q : tdy_q;
  assign tmin    = xmaj_q ? tdy_q : tdx_q;
  assign err_nxt = err_q - (err_ge ? $signed({2'b00, tmaj}) : '0)
                 + $signed({2'b00, tmin});
  assign move_x  = xmaj_q || err_ge;
  assign move_y  = !xmaj_q || err_ge;
  assign inc_x   = sxn_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
  assign inc_y   = syn_q ? {COORD_BITS{1'b1}} : COORD_BITS'(1);

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (take_i) begin
      if (cmd_i == CMD_START) begin
        active_q <= 1'b1;
      end else if (active_q && done) begin
        active_q <= 1'b0;
      end
    end
  end

  // line payload
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      if (cmd_i == CMD_START) begin
        cur_x_q  <= start_x_i;
        cur_y_q  <= start_y_i;
        stop_x_q <= end_x_i;
        stop_y_q <= end_y_i;
        err_q    <= err_init;
        tdx_q    <= tdx;
        tdy_q    <= tdy;
        sxn_q    <= dx[DW-1] || (dx == '0);
        syn_q    <= dy[DW-1] || (dy == '0);
        xmaj_q   <= xmaj;
        color_q  <= color_i;
        alpha_q  <= alpha_i;
        blend_q  <= blend_i;
      end else if (active_q && !done) begin
        err_q <= err_nxt;
        if (move_x) begin
          cur_x_q <= cur_x_q + $signed(inc_x);
        end
        if (move_y) begin
          cur_y_q <= cur_y_q + $signed(inc_y);
        end
      end
    end
  end

  assign stat_o.pix_ok = take_i && (cmd_i == CMD_STEP) && active_q;
  assign stat_o.last   = done;
  assign cur_x_o = cur_x_q;
  assign cur_y_o = cur_y_q;
  assign color_o = color_q;
  assign alpha_o = alpha_q;
  assign blend_o = blend_q;

endmodule

>>> design/bresenham_line_stepper_top.sv
// bresenham_line_stepper_top: a step word's pixel is registered in the clip stage,
// then in the offset multiply-add stage; one word accepted per cycle,
// the input stalls only while both stages are full and the output is stalled.
// Start words and steps on an idle line give no pixel.
// Reset (async, active low) ends any line, empties both stages, and sets the
// clip window to 0..2047 in both axes and the pitch to 4096 bytes.
module bresenham_line_stepper_top import bls_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic        [CfgIdxW-1:0]    cfg_idx_i,
  input  logic        [CfgDataW-1:0]   cfg_wdata_i,
  // input words
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic        [ColorW-1:0]     color_i,
  input  logic        [AlphaW-1:0]     alpha_i,
  input  logic                         blend_i,
  // output words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o,
  output logic                         visible_o,
  output logic        [OffsetW-1:0]    byte_offset_o,
  output logic        [ColorW-1:0]     pixel_color_o,
  output logic        [AlphaW-1:0]     pixel_alpha_o,
  output logic                         pixel_blend_o,
  output logic                         last_o
);

  localparam int CmpW  = (COORD_BITS > ClipHiW) ? COORD_BITS : ClipHiW;
  localparam int ProdW = COORD_BITS + PitchW;

  // configuration registers
  logic [ClipLoW-1:0] left_q, top_q;
  logic [ClipHiW-1:0] right_q, bottom_q;
  logic [PitchW-1:0]  pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= ClipLeftRst;
      top_q    <= ClipTopRst;
      right_q  <= ClipRightRst;
      bottom_q <= ClipBottomRst;
      pitch_q  <= PitchRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CLIP_LEFT:   left_q   <= cfg_wdata_i[ClipLoW-1:0];
        REG_CLIP_TOP:    top_q    <= cfg_wdata_i[ClipLoW-1:0];
        REG_CLIP_RIGHT:  right_q  <= cfg_wdata_i[ClipHiW-1:0];
        REG_CLIP_BOTTOM: bottom_q <= cfg_wdata_i[ClipHiW-1:0];
        REG_PITCH:       pitch_q  <= cfg_wdata_i[PitchW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_q, out_valid_q;
  logic adv, ready, take;

  assign adv        = !out_valid_q || !out_stall_i;
  assign ready      = !s1_valid_q || adv;
  assign take       = in_valid_i && ready;
  assign in_stall_o = !ready;

  // line stepping core
  step_stat_t                   stat;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic        [ColorW-1:0]     h_color;
  logic        [AlphaW-1:0]     h_alpha;
  logic                         h_blend;

  bls_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .cmd_i     (cmd_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .color_i   (color_i),
    .alpha_i   (alpha_i),
    .blend_i   (blend_i),
    .stat_o    (stat),
    .cur_x_o   (cur_x),
    .cur_y_o   (cur_y),
    .color_o   (h_color),
    .alpha_o   (h_alpha),
    .blend_o   (h_blend)
  );

  // clip test on the current pixel
  logic [CmpW-1:0] x_u, y_u;
  logic            vis;

  assign x_u = CmpW'($unsigned(cur_x));
  assign y_u = CmpW'($unsigned(cur_y));
  assign vis = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1]
            && (x_u >= CmpW'(left_q)) && (x_u < CmpW'(right_q))
            && (y_u >= CmpW'(top_q))  && (y_u < CmpW'(bottom_q));

  // stage 1: pixel and clip result
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic                         s1_vis_q, s1_last_q, s1_blend_q;
  logic        [ColorW-1:0]     s1_color_q;
  logic        [AlphaW-1:0]     s1_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= stat.pix_ok;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.pix_ok) begin
      s1_x_q     <= cur_x;
      s1_y_q     <= cur_y;
      s1_vis_q   <= vis;
      s1_last_q  <= stat.last;
      s1_color_q <= h_color;
      s1_alpha_q <= h_alpha;
      s1_blend_q <= h_blend;
    end
  end

  // byte offset: y * pitch + 2x, zero when clipped
  logic [ProdW-1:0]   prod, sum;
  logic [OffsetW-1:0] off_d;

  assign prod  = ProdW'($unsigned(s1_y_q)) * ProdW'(pitch_q);
  assign sum   = prod + ProdW'({$unsigned(s1_x_q), 1'b0});
  assign off_d = s1_vis_q ? OffsetW'(sum) : '0;

  // stage 2: output register
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                         out_vis_q, out_last_q, out_blend_q;
  logic        [OffsetW-1:0]    out_off_q;
  logic        [ColorW-1:0]     out_color_q;
  logic        [AlphaW-1:0]     out_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_x_q     <= s1_x_q;
      out_y_q     <= s1_y_q;
      out_vis_q   <= s1_vis_q;
      out_off_q   <= off_d;
      out_color_q <= s1_color_q;
      out_alpha_q <= s1_alpha_q;
      out_blend_q <= s1_blend_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pix_x_o       = out_x_q;
  assign pix_y_o       = out_y_q;
  assign visible_o     = out_vis_q;
  assign byte_offset_o = out_off_q;
  assign pixel_color_o = out_color_q;
  assign pixel_alpha_o = out_alpha_q;
  assign pixel_blend_o = out_blend_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  // input stalls only when both stages hold a word and the output is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // clipped pixels carry a zero offset
  a_clip_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !visible_o) |-> (byte_offset_o == '0))
    else $error("nonzero offset on a clipped pixel");

  // a visible pixel never has a negative coordinate
  a_vis_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && visible_o) |-> (!pix_x_o[COORD_BITS-1] && !pix_y_o[COORD_BITS-1]))
    else $error("visible pixel with negative coordinate");

  // a start word never produces a pixel in stage 1
  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (cmd_i == CMD_START)) |=> !s1_valid_q)
    else $error("pixel produced by a start word");
`endif

endmodule
